>>> rtl/core/sle_pkg.sv
package sle_pkg;

  localparam int DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_DEL_MIN  = 3'd1,
    CMD_REVERSE  = 3'd2,
    CMD_DEL_EQ   = 3'd3,
    CMD_DEL_RNG  = 3'd4,
    CMD_DEDUP    = 3'd5,
    CMD_FIND_INS = 3'd6,
    CMD_READ     = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] operand_value;
    logic signed [31:0] upper_bound;
    logic [6:0]         position;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] result_value;
    logic [6:0]         length_now;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,       // issue read at ridx
    ST_WAIT,     // read data lands
    ST_USE,      // act on read data
    ST_WR,       // write wval at widx
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/sequential_list_engine.sv
// sequential_list_engine: a list of signed 32-bit words plus a length.
// Input channel in_valid/in_ready/in_data carries one command (insert,
// delete minimum, reverse, delete equal, delete range, dedup,
// find-or-insert, read). Result channel out_valid/out_ready/out_data
// returns exactly one result per command: ok flag, value, new length.
// Every command is run by one sequencer over a one-write, one-read store.
// A rejected command goes straight to its result. The others work through
// the store entry by entry: insert shifts entries up, delete minimum scans
// and moves the last entry into the gap, delete equal, delete range and
// dedup compact the kept entries, reverse swaps pairs, and find-or-insert
// runs a binary search followed by a swap with the next entry or an insert shift.
// in_ready is high only while the block is idle and no result is waiting,
// so one command runs at a time and the next one is taken the cycle after
// the result transfer.
// The result register holds until out_ready; while the receiver stalls
// no new command is taken.
// Reset (rst_n low, synchronous) empties the list; store contents are
// not cleared and need no clearing pass.
module sequential_list_engine #(
  parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sle_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sle_pkg::out_item_t out_data
);
  import sle_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = CW + 2; // signed index width, room for lo + hi

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;

  state_t state_r, state_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic signed [31:0] val_r, val_nxt, upr_r, upr_nxt;
  logic [CW-1:0]      pos_r, pos_nxt, cnt_r, cnt_nxt;
  logic [CW-1:0]      i_r, i_nxt, k_r, k_nxt;
  logic signed [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic signed [31:0] tmp_r, tmp_nxt, wval_r, wval_nxt;
  logic [CW-1:0]      ridx_r, ridx_nxt, widx_r, widx_nxt;
  logic               ok_r, ok_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic               ov_r;
  state_t             ret_r, ret_nxt;

  logic signed [IW-1:0] mid;
  logic in_fire, out_fire, in_rng;
  logic [CW-1:0] last;

  assign in_ready  = (state_r == ST_IDLE) && !ov_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = ov_r && out_ready;
  assign out_valid = ov_r;
  assign out_data  = '{ok: ok_r, result_value: res_r,
                       length_now: 7'(cnt_r)};
  assign mid  = IW'((lo_r + hi_r) >>> 1);
  assign last = cnt_r - CW'(1);
  assign in_rng = (cmd_r == CMD_DEL_EQ) ? (rdata_r == val_r)
                : (rdata_r >= val_r && rdata_r <= upr_r);

  // store: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == ST_WR) mem[widx_r[AW-1:0]] <= wval_r;
    rdata_r <= mem[ridx_r[AW-1:0]];
  end

  // next state
  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; val_nxt = val_r; upr_nxt = upr_r;
    pos_nxt = pos_r; cnt_nxt = cnt_r; i_nxt = i_r; k_nxt = k_r;
    lo_nxt = lo_r; hi_nxt = hi_r; ph_nxt = ph_r; tmp_nxt = tmp_r;
    wval_nxt = wval_r; ridx_nxt = ridx_r; widx_nxt = widx_r;
    ok_nxt = ok_r; res_nxt = res_r; ret_nxt = ret_r;
    case (state_r)
      ST_IDLE: if (in_fire) begin
        cmd_nxt = in_data.command; val_nxt = in_data.operand_value;
        upr_nxt = in_data.upper_bound;
        pos_nxt = (in_data.position > 7'(DEPTH)) ? CW'(DEPTH + 1 > 127 ? 127 : DEPTH)
                  : CW'(in_data.position);
        ok_nxt = 1'b1; res_nxt = '0; ph_nxt = '0; k_nxt = '0;
        state_nxt = ST_DONE;
        case (cmd_t'(in_data.command))
          CMD_INSERT: begin
            if (cnt_r >= CW'(DEPTH) || CW'(in_data.position) > cnt_r ||
                in_data.position > 7'(DEPTH)) ok_nxt = 1'b0;
            else begin
              i_nxt = cnt_r; state_nxt = ST_USE; ph_nxt = 2'd0;
            end
          end
          CMD_DEL_MIN: begin
            if (cnt_r == '0) ok_nxt = 1'b0;
            else begin ridx_nxt = '0; i_nxt = '0; state_nxt = ST_WAIT; end
          end
          CMD_REVERSE, CMD_DEL_EQ, CMD_DEDUP: begin
            if (cnt_r != '0) begin
              i_nxt = '0; ridx_nxt = '0; state_nxt = ST_WAIT;
            end
          end
          CMD_DEL_RNG: begin
            if (in_data.operand_value >= in_data.upper_bound) ok_nxt = 1'b0;
            else if (cnt_r != '0) begin
              i_nxt = '0; ridx_nxt = '0; state_nxt = ST_WAIT;
            end
          end
          CMD_FIND_INS: begin
            lo_nxt = '0; hi_nxt = IW'(cnt_r) - IW'(1); state_nxt = ST_USE;
          end
          default: begin
            if (in_data.position < 7'(DEPTH) && CW'(in_data.position) < cnt_r) begin
              ridx_nxt = CW'(in_data.position); state_nxt = ST_WAIT;
            end else ok_nxt = 1'b0;
          end
        endcase
      end
      ST_RD: state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = ST_USE;
      ST_WR: state_nxt = ret_r;
      ST_USE: begin
        case (cmd_t'(cmd_r))
          CMD_INSERT, CMD_FIND_INS: begin
            if (cmd_r == CMD_FIND_INS && ph_r == 2'd0) begin
              // binary search step
              if (lo_r > hi_r) begin
                if (cnt_r >= CW'(DEPTH)) begin ok_nxt = 1'b0; state_nxt = ST_DONE; end
                else begin pos_nxt = CW'(lo_r); i_nxt = cnt_r; ph_nxt = 2'd2; end
              end else begin ridx_nxt = CW'(mid); ph_nxt = 2'd1; state_nxt = ST_RD; end
            end else if (cmd_r == CMD_FIND_INS && ph_r == 2'd1) begin
              if (rdata_r < val_r) begin lo_nxt = mid + IW'(1); ph_nxt = 2'd0; end
              else if (rdata_r > val_r) begin hi_nxt = mid - IW'(1); ph_nxt = 2'd0; end
              else if (CW'(mid) + CW'(1) < cnt_r) begin
                tmp_nxt = rdata_r; i_nxt = CW'(mid); ridx_nxt = CW'(mid) + CW'(1);
                ph_nxt = 2'd3; state_nxt = ST_RD;
              end else state_nxt = ST_DONE;
            end else if (cmd_r == CMD_FIND_INS && ph_r == 2'd3) begin
              // swap: mid <- next, then next <- old mid
              if (k_r == '0) begin
                widx_nxt = i_r; wval_nxt = rdata_r; k_nxt = CW'(1);
                ret_nxt = ST_USE; state_nxt = ST_WR;
              end else begin
                widx_nxt = i_r + CW'(1); wval_nxt = tmp_r;
                ret_nxt = ST_DONE; state_nxt = ST_WR;
              end
            end else begin
              // shift up: i from cnt down to pos+1 copies i-1 to i
              if (i_r > pos_r) begin
                if (k_r == '0) begin
                  ridx_nxt = i_r - CW'(1); k_nxt = CW'(1); state_nxt = ST_RD;
                end else begin
                  widx_nxt = i_r; wval_nxt = rdata_r; k_nxt = '0;
                  i_nxt = i_r - CW'(1); ret_nxt = ST_USE; state_nxt = ST_WR;
                end
              end else begin
                widx_nxt = pos_r; wval_nxt = val_r; cnt_nxt = cnt_r + CW'(1);
                ret_nxt = ST_DONE; state_nxt = ST_WR;
              end
            end
          end
          CMD_DEL_MIN: begin
            // scan for first minimum; i holds index of current read
            if (i_r == '0 || rdata_r < tmp_r) begin
              tmp_nxt = rdata_r; k_nxt = i_r;
            end
            if (ph_r == 2'd1) begin
              widx_nxt = k_r; wval_nxt = rdata_r; cnt_nxt = last;
              ret_nxt = ST_DONE; state_nxt = ST_WR;
              tmp_nxt = tmp_r; k_nxt = k_r;
            end else if (i_r == last) begin
              res_nxt = (i_r == '0 || rdata_r < tmp_r) ? rdata_r : tmp_r;
              ph_nxt = 2'd1; ridx_nxt = last; state_nxt = ST_RD;
            end else begin
              i_nxt = i_r + CW'(1); ridx_nxt = i_r + CW'(1); state_nxt = ST_RD;
            end
          end
          CMD_REVERSE: begin
            // high index is last - i; ph0 keeps low and reads high, ph1 writes low, ph2 writes high
            if (CW'(i_r) >= CW'(cnt_r >> 1)) state_nxt = ST_DONE;
            else if (ph_r == 2'd0) begin
              tmp_nxt = rdata_r; ridx_nxt = last - i_r; ph_nxt = 2'd1; state_nxt = ST_RD;
            end else if (ph_r == 2'd1) begin
              widx_nxt = i_r; wval_nxt = rdata_r; ph_nxt = 2'd2;
              ret_nxt = ST_USE; state_nxt = ST_WR;
            end else begin
              widx_nxt = last - i_r; wval_nxt = tmp_r; ph_nxt = 2'd0;
              i_nxt = i_r + CW'(1); ridx_nxt = i_r + CW'(1);
              ret_nxt = ST_RD; state_nxt = ST_WR;
            end
          end
          CMD_DEL_EQ, CMD_DEL_RNG: begin
            // compaction: keep entries outside the range
            if (ph_r == 2'd0 && !in_rng) begin
              widx_nxt = k_r; wval_nxt = rdata_r; k_nxt = k_r + CW'(1);
              ph_nxt = 2'd1; ret_nxt = ST_USE; state_nxt = ST_WR;
            end else if (i_r == last) begin
              cnt_nxt = (ph_r == 2'd0) ? k_r : k_r; state_nxt = ST_DONE;
            end else begin
              ph_nxt = 2'd0; i_nxt = i_r + CW'(1); ridx_nxt = i_r + CW'(1);
              state_nxt = ST_RD;
            end
          end
          CMD_DEDUP: begin
            // tmp holds previous entry; k counts kept
            if (ph_r == 2'd0 && (i_r == '0 || rdata_r != tmp_r)) begin
              widx_nxt = k_r; wval_nxt = rdata_r; k_nxt = k_r + CW'(1);
              tmp_nxt = rdata_r; ph_nxt = 2'd1; ret_nxt = ST_USE; state_nxt = ST_WR;
            end else if (i_r == last) begin
              cnt_nxt = k_r; state_nxt = ST_DONE;
            end else begin
              ph_nxt = 2'd0; i_nxt = i_r + CW'(1); ridx_nxt = i_r + CW'(1);
              state_nxt = ST_RD;
            end
          end
          default: begin
            res_nxt = rdata_r; state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: if (!ov_r || out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt;
      if (state_r == ST_DONE && (!ov_r || out_fire)) ov_r <= 1'b1;
      else if (out_fire) ov_r <= 1'b0;
    end
    cmd_r <= cmd_nxt; val_r <= val_nxt; upr_r <= upr_nxt; pos_r <= pos_nxt;
    i_r <= i_nxt; k_r <= k_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; ph_r <= ph_nxt;
    tmp_r <= tmp_nxt; wval_r <= wval_nxt; ridx_r <= ridx_nxt; widx_r <= widx_nxt;
    ret_r <= ret_nxt;
    ok_r <= ok_nxt; res_r <= res_nxt;
  end

`ifndef SYNTHESIS
  a_len: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(DEPTH))
    else $error("length beyond depth");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> $stable(cnt_r)) else $error("length moved under stall");
`endif

endmodule
